FILE: src/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared transaction types, the initial chaining value and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

  // One input transaction: a big-endian message word with its byte count.
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_item;
  } in_item_t;

  // One result transaction: the 256-bit digest in four 64-bit words.
  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_upper_mid;
    logic [63:0] digest_lower_mid;
    logic [63:0] digest_low;
  } out_item_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  // Standard initial chaining value, listed from word 7 down to word 0.
  localparam logic [7:0][31:0] Iv = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  // Rotate left by a nonzero amount below 32.
  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  // Round constant rotated left by the round number mod 32 (computed, not a table).
  function automatic logic [31:0] round_const(input logic [5:0] j);
    logic [31:0] t;
    logic [4:0]  s;
    t = (j < 6'd16) ? TLow : THigh;
    s = j[4:0];
    if (s == 5'd0) begin
      return t;
    end
    return (t << s) | (t >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

`default_nettype wire

FILE: src/sm3_ram.sv
// ----------------------------------------------------------------------------
// SM3 generic RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/sm3_hash_engine_core.sv
// ----------------------------------------------------------------------------
// SM3 hash engine core
// Streaming SM3 hash with the message block held in a word RAM.
// ----------------------------------------------------------------------------
// Input channel: one transaction carries a big-endian message word, a count
// of valid leading bytes (0 to 4, values above 4 count as 4) and a last flag.
// Output channel: one transaction, the 256-bit digest, follows each last word.
// Each input transaction is accepted in S_IDLE, has its bytes appended one
// by one in S_BYTES and then finishes the word. Whole words are written into
// a 16 x 32 block RAM.
// Each filled block is streamed from the RAM into the message schedule
// window (one RAM read a cycle), run through 64 rounds (one round per cycle)
// and folded into the chaining value; the engine takes no new word meanwhile.
// A last word then appends the padding bytes, makes two length writes, runs
// one or two compressions and posts the digest.
// in_stall_o is high while a transaction is at work; RAM read data is used
// only in S_LOAD, when no entry is written, so no forwarding is needed.
// The digest register holds while out_stall_i is high; the block keeps taking
// the next message and waits only if a second digest is ready first.
// Reset restores the initial chaining value and clears counts and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sm3_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sm3_pkg::out_item_t      out_data_o
);

  import sm3_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_BYTES  = 9'b000000010,
    S_PAD    = 9'b000000100,
    S_LEN_HI = 9'b000001000,
    S_LEN_LO = 9'b000010000,
    S_LOAD   = 9'b000100000,
    S_ROUND  = 9'b001000000,
    S_FOLD   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [31:0]       word_q, word_d;
  logic [2:0]        nbytes_q, nbytes_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              last_q, last_d;
  logic              pad_first_q, pad_first_d;
  logic [5:0]        fill_q, fill_d;
  logic [63:0]       bitlen_q, bitlen_d;
  logic [31:0]       part_q, part_d;
  logic [4:0]        load_q, load_d;
  logic [5:0]        round_q, round_d;
  logic [7:0][31:0]  chain_q, chain_d;
  logic [7:0][31:0]  work_q, work_d;
  logic [15:0][31:0] win_q, win_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         digest_q, digest_d;

  // RAM ports.
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  sm3_ram #(
    .Width (32),
    .Depth (BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Byte to append this cycle and the partial word with it merged in.
  logic [7:0]  app_byte;
  logic [31:0] merged;

  always_comb begin
    app_byte = (state_q == S_PAD) ? (pad_first_q ? PadMark : 8'h00) : word_q[31:24];
    merged   = part_q;
    case (fill_q[1:0])
      2'd0:    merged[31:24] = app_byte;
      2'd1:    merged[23:16] = app_byte;
      2'd2:    merged[15:8]  = app_byte;
      2'd3:    merged[7:0]   = app_byte;
      default: merged        = part_q;
    endcase
  end

  // One compression round with the message schedule window.
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic        early;

  always_comb begin
    early = (round_q < 6'd16);
    a12   = rotl(work_q[0], 12);
    ss1   = rotl(a12 + work_q[4] + round_const(round_q), 7);
    ss2   = ss1 ^ a12;
    if (early) begin
      ff = work_q[0] ^ work_q[1] ^ work_q[2];
      gg = work_q[4] ^ work_q[5] ^ work_q[6];
    end else begin
      ff = (work_q[0] & work_q[1]) | (work_q[0] & work_q[2]) | (work_q[1] & work_q[2]);
      gg = (work_q[4] & work_q[5]) | (~work_q[4] & work_q[6]);
    end
    tt1   = ff + work_q[3] + ss2 + (win_q[0] ^ win_q[4]);
    tt2   = gg + work_q[7] + ss1 + win_q[0];
    w_new = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 15))
            ^ rotl(win_q[3], 7) ^ win_q[10];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    word_d      = word_q;
    nbytes_d    = nbytes_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    pad_first_d = pad_first_q;
    fill_d      = fill_q;
    bitlen_d    = bitlen_q;
    part_d      = part_q;
    load_d      = load_q;
    round_d     = round_q;
    chain_d     = chain_q;
    work_d      = work_q;
    win_d       = win_q;
    out_valid_d = out_valid_q && out_stall_i;
    digest_d    = digest_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[5:2];
    ram_wdata   = merged;
    ram_raddr   = load_q[3:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d   = in_data_i.message_word;
          nbytes_d = (in_data_i.valid_bytes > 3'd4) ? 3'd4 : in_data_i.valid_bytes;
          last_d   = in_data_i.last_item;
          cnt_d    = 3'd0;
          state_d  = S_BYTES;
        end
      end

      S_BYTES: begin
        if (cnt_q != nbytes_q) begin
          part_d = merged;
          ram_we = (fill_q[1:0] == 2'd3);
          word_d = {word_q[23:0], 8'h00};
          cnt_d  = cnt_q + 3'd1;
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            bitlen_d = bitlen_q + 64'd512;
            ret_d    = S_BYTES;
            load_d   = 5'd0;
            state_d  = S_LOAD;
          end
        end else if (last_q) begin
          pad_first_d = 1'b1;
          state_d     = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_PAD: begin
        if (!pad_first_q && fill_q == LenPos) begin
          state_d = S_LEN_HI;
        end else begin
          if (pad_first_q) begin
            bitlen_d = bitlen_q + {55'd0, fill_q, 3'd0};
          end
          pad_first_d = 1'b0;
          part_d      = merged;
          ram_we      = (fill_q[1:0] == 2'd3);
          fill_d      = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            ret_d   = S_PAD;
            load_d  = 5'd0;
            state_d = S_LOAD;
          end
        end
      end

      S_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = 4'd14;
        ram_wdata = bitlen_q[63:32];
        state_d   = S_LEN_LO;
      end

      S_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = 4'd15;
        ram_wdata = bitlen_q[31:0];
        ret_d     = S_DONE;
        load_d    = 5'd0;
        state_d   = S_LOAD;
      end

      // Stream the block into the schedule window, one word a cycle.
      S_LOAD: begin
        load_d = load_q + 5'd1;
        if (load_q != 5'd0) begin
          win_d = {ram_rdata, win_q[15:1]};
        end
        if (load_q == 5'd16) begin
          work_d  = chain_q;
          round_d = 6'd0;
          state_d = S_ROUND;
        end
      end

      S_ROUND: begin
        work_d[0] = tt1;
        work_d[1] = work_q[0];
        work_d[2] = rotl(work_q[1], 9);
        work_d[3] = work_q[2];
        work_d[4] = perm0(tt2);
        work_d[5] = work_q[4];
        work_d[6] = rotl(work_q[5], 19);
        work_d[7] = work_q[6];
        win_d     = {w_new, win_q[15:1]};
        round_d   = round_q + 6'd1;
        if (round_q == 6'(Rounds - 1)) begin
          state_d = S_FOLD;
        end
      end

      S_FOLD: begin
        chain_d = chain_q ^ work_q;
        state_d = ret_q;
      end

      // Post the digest once the output register is free, then restart.
      // Chaining word 0 goes to the top bits of the digest.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          digest_d    = {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                         chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
          chain_d     = Iv;
          fill_d      = 6'd0;
          bitlen_d    = 64'd0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= 6'd0;
      bitlen_q    <= 64'd0;
      chain_q     <= Iv;
      out_valid_q <= 1'b0;
      pad_first_q <= 1'b0;
      cnt_q       <= 3'd0;
      load_q      <= 5'd0;
      round_q     <= 6'd0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      bitlen_q    <= bitlen_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
      pad_first_q <= pad_first_d;
      cnt_q       <= cnt_d;
      load_q      <= load_d;
      round_q     <= round_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    nbytes_q <= nbytes_d;
    last_q   <= last_d;
    part_q   <= part_d;
    work_q   <= work_d;
    win_q    <= win_d;
    digest_q <= digest_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = digest_q;

endmodule

`default_nettype wire

FILE: src/sm3_hash_engine_chk.sv
// ----------------------------------------------------------------------------
// SM3 hash engine checker
// Port-level assertions on the hash engine core, attached with a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire sm3_pkg::out_item_t out_data_o
);

  // A stalled digest stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("digest dropped while stalled");

  // A stalled digest does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("digest changed while stalled");

  // The engine works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // The handshake outputs are always known once out of reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({out_valid_o, in_stall_o}))
    else $error("unknown handshake output");

endmodule

bind sm3_hash_engine_core sm3_hash_engine_chk u_sm3_chk (.*);

`default_nettype wire

FILE: sim/sm3_hash_engine_core_test.sv
// ----------------------------------------------------------------------------
// SM3 hash engine core testbench
// Drives message words with random gaps, predicts each digest with a local
// SM3 model and checks every digest transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Local SM3 model plus a queue of expected digests.
class sm3_digest_board;
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  int unsigned nbytes;
  logic [63:0] nbits;
  sm3_pkg::out_item_t digest_q[$];
  int unsigned errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
              32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
    nbytes = 0;
    nbits = '0;
  endfunction

  function logic [31:0] rl(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[68];
    logic [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, t1, t2, x;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = (x ^ rl(x, 15) ^ rl(x, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int j = 0; j < 64; j++) begin
      t = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
      a12 = rl(a, 12);
      ss1 = rl(a12 + e + rl(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      t1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      t2 = gg + h + ss1 + w[j];
      d = c; c = rl(b, 9); b = a; a = t1;
      h = g; g = rl(f, 19); f = e; e = t2 ^ rl(t2, 9) ^ rl(t2, 17);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endfunction

  function void put(int unsigned pos, logic [7:0] v);
    int sh;
    sh = 24 - 8 * (pos % 4);
    blk[(pos / 4) % 16] = (blk[(pos / 4) % 16] & ~(32'hFF << sh)) | (32'(v) << sh);
  endfunction

  function void add_byte(logic [7:0] v);
    put(nbytes, v);
    nbytes = (nbytes + 1) % 64;
    if (nbytes == 0) begin
      compress();
      nbits += 512;
    end
  endfunction

  // Note one accepted input transaction.
  function void note_word(sm3_pkg::in_item_t it);
    int unsigned n;
    n = (it.valid_bytes > 4) ? 4 : it.valid_bytes;
    for (int i = 0; i < n; i++) add_byte(it.message_word[31 - 8*i -: 8]);
    if (!it.last_item) return;
    nbits += 64'(nbytes) << 3;
    put(nbytes, 8'h80);
    nbytes++;
    if (nbytes > 56) begin
      while (nbytes < 64) begin put(nbytes, 8'h00); nbytes++; end
      compress();
      nbytes = 0;
    end
    while (nbytes < 56) begin put(nbytes, 8'h00); nbytes++; end
    blk[14] = nbits[63:32];
    blk[15] = nbits[31:0];
    compress();
    digest_q.push_back({chain[0], chain[1], chain[2], chain[3],
                        chain[4], chain[5], chain[6], chain[7]});
    restart();
  endfunction

  // Check one digest transaction against the oldest prediction.
  function void check_digest(sm3_pkg::out_item_t got);
    sm3_pkg::out_item_t exp;
    if (digest_q.size() == 0) begin
      $error("unexpected digest %h", got);
      errors++;
      return;
    end
    exp = digest_q.pop_front();
    if (got.digest_high !== exp.digest_high) begin
      $error("digest_high exp %h got %h", exp.digest_high, got.digest_high); errors++;
    end
    if (got.digest_upper_mid !== exp.digest_upper_mid) begin
      $error("digest_upper_mid exp %h got %h", exp.digest_upper_mid, got.digest_upper_mid);
      errors++;
    end
    if (got.digest_lower_mid !== exp.digest_lower_mid) begin
      $error("digest_lower_mid exp %h got %h", exp.digest_lower_mid, got.digest_lower_mid);
      errors++;
    end
    if (got.digest_low !== exp.digest_low) begin
      $error("digest_low exp %h got %h", exp.digest_low, got.digest_low); errors++;
    end
  endfunction
endclass

module sm3_hash_engine_core_test;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  sm3_pkg::in_item_t in_data_i = '0;
  logic in_stall_o, out_valid_o;
  sm3_pkg::out_item_t out_data_o;

  sm3_digest_board board = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  sm3_hash_engine_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Offer one word and wait until it is accepted, with random gaps first.
  task automatic send_word(logic [31:0] w, logic [2:0] n, logic lst);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{message_word: w, valid_bytes: n, last_item: lst};
    do @(posedge clk_i); while (in_stall_o);
    board.note_word('{message_word: w, valid_bytes: n, last_item: lst});
  endtask

  // A well-formed message of len bytes.
  task automatic send_message(int unsigned len);
    int unsigned k;
    k = len;
    while (k > 4) begin send_word($urandom, 3'd4, 1'b0); k -= 4; end
    send_word($urandom, 3'(k), 1'b1);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Digest monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_digest(out_data_o);
  end

  // Stimulus and end of run.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, extremes, odd counts, padding boundaries.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd7, 1'b1);
    send_word(32'h00000000, 3'd5, 1'b0);
    send_word(32'hA5A5A5A5, 3'd1, 1'b0);
    send_word(32'h5A5A5A5A, 3'd2, 1'b0);
    send_word(32'h12345678, 3'd0, 1'b0);
    send_word(32'hFFFFFFFF, 3'd6, 1'b1);
    send_message(55);
    send_message(56);
    send_message(64);
    send_message(60);
    // Fill the block while the receiver holds off.
    hold_req = 1'b1;
    for (int i = 0; i < 5; i++) send_message($urandom_range(0, 8));
    wait (!hold_req);
    // Random part: mostly messages, some broken words.
    for (int n = 0; n < 820;) begin
      if (n > 700) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 40);
        send_message(len);
        n += len / 4 + 1;
      end
    end
    send_word(32'h0, 3'd0, 1'b1);
    in_valid_i <= 1'b0;
    wait (board.digest_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(12 * 1500000);
    $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire

FILE: sim.f
src/sm3_pkg.sv
src/sm3_ram.sv
src/sm3_hash_engine_core.sv
src/sm3_hash_engine_chk.sv
sim/sm3_hash_engine_core_test.sv
